### design/srs_pkg.sv
package srs_pkg;

    localparam int ADDR_BITS    = 48;
    localparam int MAX_SEGMENTS = 64;
    localparam int OFF_W        = ADDR_BITS + 1;
    localparam int PHYS_W       = 56;
    localparam int CNT_W        = 32;
    localparam int CH_W         = 9;
    localparam int IDX_W        = 8;
    localparam int BS_W         = 5;
    localparam int BS_MIN       = 9;
    localparam int BS_MAX       = 30;
    localparam int BS_RESET     = 23;
    localparam int BLK_W        = ADDR_BITS - BS_MIN;
    localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int CQ_DEPTH     = 4;
    localparam int CQ_PTR_W     = $clog2(CQ_DEPTH);
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_INDEX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd2;

    localparam logic [2:0] REQ_WR_OFF = 3'd0;
    localparam logic [2:0] REQ_RD_OFF = 3'd1;
    localparam logic [2:0] REQ_WR_POS = 3'd2;
    localparam logic [2:0] REQ_RD_POS = 3'd3;
    localparam logic [2:0] REQ_SEEK   = 3'd4;

    localparam logic [1:0] WH_START = 2'd0;
    localparam logic [1:0] WH_CUR   = 2'd1;
    localparam logic [1:0] WH_END   = 2'd2;
    localparam logic [1:0] WH_BAD   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_WHNC  = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_TOO_MANY  = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [IDX_W-1:0] idx;
        logic [BS_W-1:0]  bs;
    } cfg_t;

    typedef struct packed {
        logic                 split;
        logic                 wr;
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] start;
        logic [CNT_W-1:0]     count;
        logic [ADDR_BITS-1:0] fin;
        logic [BLK_W-1:0]     sb;
        logic [SEG_W-1:0]     nseg;
        logic [ADDR_BITS-1:0] pos;
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_RANGE,
        F_SPAN
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SINGLE,
        B_SETUP,
        B_BASE,
        B_EMIT
    } back_state_t;

endpackage

### design/srs_front.sv
module srs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  srs_pkg::cfg_t               cfg,
    input  logic                        push,
    input  logic [2:0]                  req_type,
    input  logic signed [srs_pkg::OFF_W-1:0] offset,
    input  logic [srs_pkg::CNT_W-1:0]   byte_count,
    input  logic [1:0]                  whence,
    output logic                        full,
    output logic                        cmd_push,
    output srs_pkg::cmd_t               cmd,
    input  logic                        cmd_full
);
    import srs_pkg::*;

    front_state_t         state_reg, state_next;
    logic [2:0]           type_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [1:0]           whence_reg;
    logic [ADDR_BITS-1:0] pos_reg, pos_next;
    logic [ADDR_BITS-1:0] size_reg;
    logic [ADDR_BITS-1:0] start_reg, start_next;
    logic [ADDR_BITS-1:0] end_reg, end_next;
    logic [ADDR_BITS-1:0] newpos_reg, newpos_next;
    logic [1:0]           status_reg, status_next;

    logic                 neg;
    logic [OFF_W-1:0]     mag;
    logic [ADDR_BITS-1:0] seek_base;
    logic [ADDR_BITS+1:0] seek_sum;
    logic [ADDR_BITS+1:0] seek_diff;
    logic                 is_seek;
    logic                 at_offset;
    logic                 at_pos;
    logic [OFF_W-1:0]     acc_end;

    logic [BLK_W-1:0]     sb;
    logic [BLK_W-1:0]     eb;
    logic [BLK_W-1:0]     span;
    logic                 too_many;
    logic                 one_ch;
    logic [1:0]           status_fin;
    logic                 ok;
    logic                 is_wr;

    // range stage
    always_comb
    begin
        neg       = off_reg[OFF_W-1];
        mag       = neg ? (~off_reg + OFF_W'(1)) : off_reg;
        is_seek   = (type_reg == REQ_SEEK);
        at_offset = (type_reg == REQ_WR_OFF) || (type_reg == REQ_RD_OFF);
        unique case (whence_reg)
            WH_START: seek_base = '0;
            WH_CUR:   seek_base = pos_reg;
            WH_END:   seek_base = size_reg;
            WH_BAD:   seek_base = '0;
        endcase
        seek_sum  = {2'b00, seek_base} + {1'b0, mag};
        seek_diff = {2'b00, seek_base} - {1'b0, mag};
        start_next = at_offset ? mag[ADDR_BITS-1:0] : pos_reg;
        acc_end    = {1'b0, start_next} + OFF_W'(count_reg);
        end_next   = acc_end[ADDR_BITS-1:0];
        newpos_next = neg ? seek_diff[ADDR_BITS-1:0] : seek_sum[ADDR_BITS-1:0];
        if (is_seek)
        begin
            if (whence_reg == WH_BAD)
                status_next = ST_BAD_WHNC;
            else if (neg ? seek_diff[ADDR_BITS+1] : (seek_sum[ADDR_BITS+1:ADDR_BITS] != 2'b00))
                status_next = ST_RANGE;
            else
                status_next = ST_OK;
        end
        else if ((at_offset && neg) || acc_end[ADDR_BITS])
            status_next = ST_RANGE;
        else
            status_next = ST_OK;
    end

    // span stage
    always_comb
    begin
        at_pos   = (type_reg == REQ_WR_POS) || (type_reg == REQ_RD_POS);
        sb       = BLK_W'(start_reg >> cfg.bs);
        eb       = BLK_W'(end_reg >> cfg.bs);
        span     = eb - sb;
        too_many = span > BLK_W'(MAX_SEGMENTS - 1);
        one_ch   = (cfg.ch == CH_W'(1));
        if (status_reg != ST_OK)
            status_fin = status_reg;
        else if (!is_seek && !one_ch && too_many)
            status_fin = ST_TOO_MANY;
        else
            status_fin = ST_OK;
        ok    = (status_fin == ST_OK);
        is_wr = (type_reg == REQ_WR_OFF) || (type_reg == REQ_WR_POS);
        if (!ok)
            pos_next = pos_reg;
        else if (is_seek)
            pos_next = newpos_reg;
        else if (at_pos)
            pos_next = end_reg;
        else
            pos_next = pos_reg;

        cmd.split  = ok && !is_seek && !one_ch;
        cmd.wr     = ok && !is_seek && is_wr;
        cmd.status = status_fin;
        cmd.start  = (ok && !is_seek) ? start_reg : '0;
        cmd.count  = (ok && !is_seek) ? count_reg : '0;
        cmd.fin    = end_reg;
        cmd.sb     = sb;
        cmd.nseg   = SEG_W'(span) + SEG_W'(1);
        cmd.pos    = pos_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
                if (push && req_type <= REQ_SEEK)
                    state_next = F_RANGE;
            F_RANGE:
                state_next = F_SPAN;
            F_SPAN:
                if (!cmd_full)
                    state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        full     = (state_reg != F_IDLE);
        cmd_push = (state_reg == F_SPAN) && !cmd_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pos_reg   <= '0;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_push)
            begin
                pos_reg <= pos_next;
                if (ok && !is_seek && (size_reg < end_reg))
                    size_reg <= end_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            type_reg   <= req_type;
            off_reg    <= offset;
            count_reg  <= byte_count;
            whence_reg <= whence;
        end
        if (state_reg == F_RANGE)
        begin
            start_reg  <= start_next;
            end_reg    <= end_next;
            newpos_reg <= newpos_next;
            status_reg <= status_next;
        end
    end

endmodule

### design/srs_cmd_fifo.sv
module srs_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  srs_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output srs_pkg::cmd_t dout,
    output logic          empty
);
    import srs_pkg::*;

    cmd_t                mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_PTR_W:0]   count_reg;

    assign full  = (count_reg == (CQ_PTR_W + 1)'(CQ_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + CQ_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + CQ_PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (CQ_PTR_W + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (CQ_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= din;
    end

endmodule

### design/srs_back.sv
module srs_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  srs_pkg::cfg_t                   cfg,
    input  logic                            cmd_empty,
    input  srs_pkg::cmd_t                   cmd_in,
    output logic                            cmd_pop,
    input  logic                            pop,
    output logic                            empty,
    output logic [srs_pkg::PHYS_W-1:0]      phys_offset,
    output logic [srs_pkg::CNT_W-1:0]       seg_len,
    output logic [srs_pkg::CNT_W-1:0]       buf_offset,
    output logic                            is_write,
    output logic                            last,
    output logic [1:0]                      status,
    output logic [srs_pkg::ADDR_BITS-1:0]   position
);
    import srs_pkg::*;

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [ADDR_BITS-1:0] prod_reg;
    logic [PHYS_W-1:0]    phys_reg;
    logic [PHYS_W-1:0]    stride_reg;
    logic [CNT_W-1:0]     boff_reg;
    logic [SEG_W-1:0]     cnt_reg;
    logic                 first_reg;
    logic                 out_valid_reg;

    logic                 out_free;
    logic                 load_single;
    logic                 load_seg;
    logic                 seg_last;
    logic [CNT_W-1:0]     bmask;
    logic [CNT_W-1:0]     s_off;
    logic [CNT_W-1:0]     e_off;
    logic [CNT_W-1:0]     len;
    logic [PHYS_W-1:0]    base_blk;

    always_comb
    begin
        bmask    = (CNT_W'(1) << cfg.bs) - CNT_W'(1);
        seg_last = (cnt_reg == SEG_W'(1));
        s_off    = first_reg ? (cmd_reg.start[CNT_W-1:0] & bmask) : '0;
        e_off    = seg_last ? (cmd_reg.fin[CNT_W-1:0] & bmask) : (bmask + CNT_W'(1));
        len      = e_off - s_off;
        base_blk = PHYS_W'(prod_reg) + PHYS_W'(cfg.idx);
    end

    always_comb
    begin
        out_free    = !out_valid_reg || pop;
        cmd_pop     = (state_reg == B_IDLE) && !cmd_empty;
        load_single = (state_reg == B_SINGLE) && out_free;
        load_seg    = (state_reg == B_EMIT) && out_free;
        empty       = !out_valid_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (!cmd_empty)
                    state_next = cmd_in.split ? B_SETUP : B_SINGLE;
            B_SINGLE:
                if (out_free)
                    state_next = B_IDLE;
            B_SETUP:
                state_next = B_BASE;
            B_BASE:
                state_next = B_EMIT;
            B_EMIT:
                if (out_free && seg_last)
                    state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_single || load_seg)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cmd_reg <= cmd_in;
        if (state_reg == B_SETUP)
            prod_reg <= ADDR_BITS'(cmd_reg.sb) * ADDR_BITS'(cfg.ch);
        if (state_reg == B_BASE)
        begin
            phys_reg   <= base_blk << cfg.bs;
            stride_reg <= PHYS_W'(cfg.ch) << cfg.bs;
            boff_reg   <= '0;
            cnt_reg    <= cmd_reg.nseg;
            first_reg  <= 1'b1;
        end
        if (load_seg)
        begin
            phys_reg  <= phys_reg + stride_reg;
            boff_reg  <= boff_reg + len;
            cnt_reg   <= cnt_reg - SEG_W'(1);
            first_reg <= 1'b0;
        end
        if (load_single)
        begin
            phys_offset <= PHYS_W'(cmd_reg.start);
            seg_len     <= cmd_reg.count;
            buf_offset  <= '0;
            is_write    <= cmd_reg.wr;
            last        <= 1'b1;
            status      <= cmd_reg.status;
            position    <= cmd_reg.pos;
        end
        else if (load_seg)
        begin
            phys_offset <= phys_reg + PHYS_W'(s_off);
            seg_len     <= len;
            buf_offset  <= boff_reg;
            is_write    <= cmd_reg.wr;
            last        <= seg_last;
            status      <= ST_OK;
            position    <= cmd_reg.pos;
        end
    end

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT) |-> (cnt_reg != '0))
        else $error("segment counter empty while emitting");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load_seg && seg_last) |=> (state_reg == B_IDLE))
        else $error("generator did not return to idle after last segment");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load_single || load_seg) |-> (!out_valid_reg || pop))
        else $error("result register overwritten before transfer");

endmodule

### design/striped_region_splitter_unit.sv
// channel   direction  handshake              contents
// request   in         push / full            req_type, offset, byte_count, whence
// result    out        empty / pop            phys_offset, seg_len, buf_offset, is_write,
//                                             last, status, position
// config    in         wr_en                  wr_index, wr_data
//
// one request at a time passes capture, range check and span check in the front
// seek, error and single-channel requests: one result, with last set
// split requests: one segment per cycle while the result register is not stalled
// reset clears position, file size, queues and config to defaults; no clearing pass
// a stalled result holds the generator; the command queue lets the front run ahead
module striped_region_splitter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [2:0]                          req_type,
    input  logic signed [srs_pkg::OFF_W-1:0]    offset,
    input  logic [srs_pkg::CNT_W-1:0]           byte_count,
    input  logic [1:0]                          whence,
    output logic                                empty,
    input  logic                                pop,
    output logic [srs_pkg::PHYS_W-1:0]          phys_offset,
    output logic [srs_pkg::CNT_W-1:0]           seg_len,
    output logic [srs_pkg::CNT_W-1:0]           buf_offset,
    output logic                                is_write,
    output logic                                last,
    output logic [1:0]                          status,
    output logic [srs_pkg::ADDR_BITS-1:0]       position,
    input  logic                                wr_en,
    input  logic [srs_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [srs_pkg::CH_W-1:0]            wr_data
);
    import srs_pkg::*;

    logic [CH_W-1:0]  ch_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [BS_W-1:0]  bs_reg;
    cfg_t             cfg;

    logic             cmd_push;
    logic             cmd_pop;
    logic             cmd_full;
    logic             cmd_empty;
    cmd_t             cmd_wr;
    cmd_t             cmd_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg  <= CH_W'(1);
            idx_reg <= '0;
            bs_reg  <= BS_W'(BS_RESET);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_CHANNELS:   ch_reg  <= wr_data;
                CFG_CHAN_INDEX: idx_reg <= wr_data[IDX_W-1:0];
                CFG_BLOCK_LOG2: bs_reg  <= wr_data[BS_W-1:0];
                default:        ;
            endcase
        end
    end

    // zero channels acts as one; block size saturates
    always_comb
    begin
        cfg.ch  = (ch_reg == '0) ? CH_W'(1) : ch_reg;
        cfg.idx = idx_reg;
        priority if (bs_reg < BS_W'(BS_MIN))
            cfg.bs = BS_W'(BS_MIN);
        else if (bs_reg > BS_W'(BS_MAX))
            cfg.bs = BS_W'(BS_MAX);
        else
            cfg.bs = bs_reg;
    end

    srs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .push       (push),
        .req_type   (req_type),
        .offset     (offset),
        .byte_count (byte_count),
        .whence     (whence),
        .full       (full),
        .cmd_push   (cmd_push),
        .cmd        (cmd_wr),
        .cmd_full   (cmd_full)
    );

    srs_cmd_fifo u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_wr),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_rd),
        .empty (cmd_empty)
    );

    srs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd_empty   (cmd_empty),
        .cmd_in      (cmd_rd),
        .cmd_pop     (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .phys_offset (phys_offset),
        .seg_len     (seg_len),
        .buf_offset  (buf_offset),
        .is_write    (is_write),
        .last        (last),
        .status      (status),
        .position    (position)
    );

endmodule

### bench/srs_segment_check.sv
module srs_segment_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic [2:0]                        req_type,
    input  logic [srs_pkg::OFF_W-1:0]         offset,
    input  logic [srs_pkg::CNT_W-1:0]         byte_count,
    input  logic [1:0]                        whence,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [srs_pkg::PHYS_W-1:0]        phys_offset,
    input  logic [srs_pkg::CNT_W-1:0]         seg_len,
    input  logic [srs_pkg::CNT_W-1:0]         buf_offset,
    input  logic                              is_write,
    input  logic                              last,
    input  logic [1:0]                        status,
    input  logic [srs_pkg::ADDR_BITS-1:0]     position,
    input  logic                              wr_en,
    input  logic [srs_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [srs_pkg::CH_W-1:0]          wr_data,
    output int                                mismatches,
    output int                                due_count,
    output int                                requests_seen,
    output int                                results_seen
);

    import srs_pkg::*;

    localparam logic [63:0] POS_MAX = (64'd1 << ADDR_BITS) - 64'd1;

    typedef struct packed {
        logic [PHYS_W-1:0]    phys;
        logic [CNT_W-1:0]     len;
        logic [CNT_W-1:0]     boff;
        logic                 wr;
        logic                 fin;
        logic [1:0]           st;
        logic [ADDR_BITS-1:0] pos;
    } segment_t;

    segment_t segments_due[$];

    logic [CH_W-1:0]      cfg_ch;
    logic [IDX_W-1:0]     cfg_idx;
    logic [BS_W-1:0]      cfg_bs;
    logic [ADDR_BITS-1:0] cur_pos;
    logic [ADDR_BITS-1:0] file_end;

    task automatic add_segment(input logic [63:0] phys, input logic [63:0] len,
                               input logic [63:0] boff, input logic wr,
                               input logic fin, input logic [1:0] st);
        segment_t s;
        s.phys = phys[PHYS_W-1:0];
        s.len  = len[CNT_W-1:0];
        s.boff = boff[CNT_W-1:0];
        s.wr   = wr;
        s.fin  = fin;
        s.st   = st;
        s.pos  = cur_pos;
        segments_due.push_back(s);
    endtask

    task automatic reject(input logic [1:0] code);
        add_segment(64'd0, 64'd0, 64'd0, 1'b0, 1'b1, code);
    endtask

    task automatic split_request(input logic [2:0] kind, input logic [OFF_W-1:0] off,
                                 input logic [CNT_W-1:0] cnt, input logic [1:0] wh);
        logic [63:0] mag;
        logic [63:0] here;
        logic [63:0] first;
        logic [63:0] fin;
        logic [63:0] sb;
        logic [63:0] eb;
        logic [63:0] blk;
        logic [63:0] blk_base;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] boff;
        logic [63:0] bmask;
        logic [63:0] chn;
        logic        neg;
        logic        wr;
        int          bsz;
        neg   = off[OFF_W-1];
        mag   = neg ? (64'd1 << OFF_W) - 64'(off) : 64'(off);
        chn   = (cfg_ch == '0) ? 64'd1 : 64'(cfg_ch);
        bsz   = (cfg_bs < BS_MIN) ? BS_MIN : ((cfg_bs > BS_MAX) ? BS_MAX : int'(cfg_bs));
        bmask = (64'd1 << bsz) - 64'd1;
        wr    = (kind == REQ_WR_OFF || kind == REQ_WR_POS);
        if (kind > REQ_SEEK)
            return;
        if (kind == REQ_SEEK)
        begin
            if (wh == WH_BAD)
            begin
                reject(ST_BAD_WHNC);
                return;
            end
            here = (wh == WH_START) ? 64'd0 :
                   ((wh == WH_CUR) ? 64'(cur_pos) : 64'(file_end));
            if (neg ? (here < mag) : (mag > POS_MAX - here))
            begin
                reject(ST_RANGE);
                return;
            end
            here = neg ? here - mag : here + mag;
            cur_pos = here[ADDR_BITS-1:0];
            add_segment(64'd0, 64'd0, 64'd0, 1'b0, 1'b1, ST_OK);
            return;
        end
        if (kind == REQ_WR_OFF || kind == REQ_RD_OFF)
        begin
            if (neg)
            begin
                reject(ST_RANGE);
                return;
            end
            first = mag;
        end
        else
            first = 64'(cur_pos);
        if (64'(cnt) > POS_MAX - first)
        begin
            reject(ST_RANGE);
            return;
        end
        fin = first + 64'(cnt);
        sb  = first >> bsz;
        eb  = fin >> bsz;
        if (chn != 64'd1 && eb - sb + 64'd1 > MAX_SEGMENTS)
        begin
            reject(ST_TOO_MANY);
            return;
        end
        if (kind == REQ_WR_POS || kind == REQ_RD_POS)
            cur_pos = fin[ADDR_BITS-1:0];
        if (64'(file_end) < fin)
            file_end = fin[ADDR_BITS-1:0];
        if (chn == 64'd1)
        begin
            add_segment(first, 64'(cnt), 64'd0, wr, 1'b1, ST_OK);
            return;
        end
        boff = 64'd0;
        for (blk = sb; blk <= eb; blk++)
        begin
            blk_base = (blk * chn + 64'(cfg_idx)) << bsz;
            lo = blk_base + ((blk == sb) ? (first & bmask) : 64'd0);
            hi = blk_base + ((blk == eb) ? (fin & bmask) : (bmask + 64'd1));
            add_segment(lo, hi - lo, boff, wr, blk == eb, ST_OK);
            boff += hi - lo;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        segment_t head;
        if (!rst_n)
        begin
            cfg_ch   = CH_W'(1);
            cfg_idx  = '0;
            cfg_bs   = BS_W'(BS_RESET);
            cur_pos  = '0;
            file_end = '0;
            segments_due.delete();
            mismatches    = 0;
            requests_seen = 0;
            results_seen  = 0;
            due_count <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    CFG_CHANNELS:   cfg_ch  = wr_data;
                    CFG_CHAN_INDEX: cfg_idx = wr_data[IDX_W-1:0];
                    CFG_BLOCK_LOG2: cfg_bs  = wr_data[BS_W-1:0];
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                results_seen++;
                if (segments_due.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end
                else
                begin
                    head = segments_due.pop_front();
                    check_field("phys_offset", 64'(head.phys), 64'(phys_offset));
                    check_field("seg_len", 64'(head.len), 64'(seg_len));
                    check_field("buf_offset", 64'(head.boff), 64'(buf_offset));
                    check_field("is_write", 64'(head.wr), 64'(is_write));
                    check_field("last", 64'(head.fin), 64'(last));
                    check_field("status", 64'(head.st), 64'(status));
                    check_field("position", 64'(head.pos), 64'(position));
                end
            end
            if (push && !full)
            begin
                requests_seen++;
                split_request(req_type, offset, byte_count, whence);
            end
            due_count <= segments_due.size();
        end
    end

endmodule

### bench/tb_striped_region_splitter_unit.sv
module tb_striped_region_splitter_unit;

    import srs_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 31;
    localparam logic [2:0] REQ_NONE_LO = 3'd5;
    localparam logic [2:0] REQ_NONE_HI = 3'd7;
    localparam logic [63:0] POS_MAX = (64'd1 << ADDR_BITS) - 64'd1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [2:0]             req_type = REQ_WR_OFF;
    logic [OFF_W-1:0]       offset = '0;
    logic [CNT_W-1:0]       byte_count = '0;
    logic [1:0]             whence = WH_START;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [PHYS_W-1:0]      phys_offset;
    logic [CNT_W-1:0]       seg_len;
    logic [CNT_W-1:0]       buf_offset;
    logic                   is_write;
    logic                   last;
    logic [1:0]             status;
    logic [ADDR_BITS-1:0]   position;
    logic                   wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   wr_index = CFG_CHANNELS;
    logic [CH_W-1:0]        wr_data = '0;

    int mismatches;
    int due_count;
    int requests_seen;
    int results_seen;
    int cycles = 0;
    int pop_wait = 0;
    int stall_draw;
    int cur_bs = BS_RESET;
    bit idle_on = 1'b1;
    bit stall_on = 1'b1;

    striped_region_splitter_unit dut (.*);

    srs_segment_check segment_check (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_wait <= 0;
        end
        else if (pop && !empty)
        begin
            stall_draw = stall_on ? $urandom_range(0, 7) : 0;
            pop_wait <= stall_draw;
            pop <= (stall_draw == 0);
        end
        else if (pop_wait != 0)
        begin
            pop_wait <= pop_wait - 1;
            pop <= (pop_wait == 1);
        end
        else
            pop <= 1'b1;
    end

    task automatic send_req(input logic [2:0] kind, input logic [OFF_W-1:0] off,
                            input logic [CNT_W-1:0] cnt, input logic [1:0] wh);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        req_type   <= kind;
        offset     <= off;
        byte_count <= cnt;
        whence     <= wh;
        do
            @(posedge clk);
        while (!(push && !full));
    endtask

    task automatic settle();
        push <= 1'b0;
        do
            @(posedge clk);
        while (due_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_cfg(input logic [CH_W-1:0] ch, input logic [IDX_W-1:0] idx,
                             input logic [BS_W-1:0] bs);
        wr_en    <= 1'b1;
        wr_index <= CFG_CHANNELS;
        wr_data  <= ch;
        @(posedge clk);
        wr_index <= CFG_CHAN_INDEX;
        wr_data  <= CH_W'(idx);
        @(posedge clk);
        wr_index <= CFG_BLOCK_LOG2;
        wr_data  <= CH_W'(bs);
        @(posedge clk);
        wr_en <= 1'b0;
        cur_bs = (bs < BS_MIN) ? BS_MIN : ((bs > BS_MAX) ? BS_MAX : int'(bs));
    endtask

    task automatic random_request(output bit counted);
        logic [63:0] blk;
        logic [63:0] span;
        logic [63:0] seek_dist;
        logic [63:0] base;
        logic [2:0]  kind;
        logic [OFF_W-1:0] off;
        logic [CNT_W-1:0] cnt;
        logic [1:0]  wh;
        int          sel;
        blk = 64'd1 << cur_bs;
        sel = $urandom_range(0, 99);
        wh  = WH_START;
        cnt = $urandom;
        if (sel < 8)
        begin
            kind = 3'($urandom_range(0, 7));
            off  = OFF_W'({$urandom, $urandom});
            wh   = 2'($urandom_range(0, 3));
        end
        else if (sel < 24)
        begin
            kind = REQ_SEEK;
            wh   = ($urandom_range(0, 9) == 0) ? WH_BAD : 2'($urandom_range(0, 2));
            seek_dist = {$urandom, $urandom} % (8 * blk);
            off  = (wh != WH_START && $urandom_range(0, 1) == 1) ?
                   OFF_W'(0) - seek_dist[OFF_W-1:0] : seek_dist[OFF_W-1:0];
        end
        else
        begin
            kind = 3'($urandom_range(REQ_WR_OFF, REQ_RD_POS));
            base = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: base = base & ((blk << 4) - 64'd1);
                1: base = base & POS_MAX & ~(blk - 64'd1);
                2: base = POS_MAX - (base & (4 * blk - 64'd1));
                default: base = base & POS_MAX;
            endcase
            off  = base[OFF_W-1:0];
            span = $urandom_range(0, 5) * blk;
            if ($urandom_range(0, 2) != 0)
                span = span + ({32'd0, $urandom} & (blk - 64'd1));
            cnt = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[CNT_W-1:0];
            if ($urandom_range(0, 19) == 0)
                cnt = $urandom;
        end
        counted = (kind <= REQ_SEEK);
        send_req(kind, off, cnt, wh);
    endtask

    initial
    begin
        int useful;
        int ch_pick;
        bit counted;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one channel, identity segments
        send_req(REQ_WR_OFF, '0, 32'd0, WH_START);
        send_req(REQ_RD_OFF, 49'h0_FFFF_FFFF_FFFF, 32'd0, WH_START);
        send_req(REQ_RD_OFF, 49'h0_FFFF_FFFF_FFFF, 32'd1, WH_START);
        send_req(REQ_WR_OFF, 49'h1_FFFF_FFFF_FFFF, 32'd8, WH_START);
        send_req(REQ_SEEK, 49'd3, 32'd0, WH_BAD);
        send_req(REQ_SEEK, 49'h0_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, WH_START);
        send_req(REQ_SEEK, 49'd1, 32'd0, WH_CUR);
        send_req(REQ_SEEK, 49'h1_0000_0000_0000, 32'd0, WH_END);
        send_req(REQ_SEEK, 49'h1_FFFF_FFFF_FFFB, 32'd0, WH_CUR);
        send_req(REQ_WR_POS, '0, 32'hFFFF_FFFF, WH_START);
        send_req(REQ_NONE_LO, 49'd5, 32'd5, WH_START);
        send_req(REQ_NONE_LO + 3'd1, 49'd6, 32'd6, WH_CUR);
        send_req(REQ_NONE_HI, 49'h1_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, WH_BAD);
        settle();

        // small blocks: boundary-aligned end, widest legal span, one past it
        apply_cfg(9'd4, 8'd1, 5'd9);
        send_req(REQ_SEEK, '0, 32'd0, WH_START);
        send_req(REQ_WR_POS, '0, 32'd1024, WH_START);
        send_req(REQ_RD_OFF, 49'd100, 32'd1000, WH_START);
        send_req(REQ_RD_OFF, '0, 32'd32768, WH_START);
        send_req(REQ_RD_OFF, '0, 32'd32767, WH_START);
        settle();

        // zero channels acts as one
        apply_cfg(9'd0, 8'd5, 5'd4);
        send_req(REQ_WR_OFF, 49'd12345, 32'd777, WH_START);
        settle();

        // slot beyond channel count, block size below range
        apply_cfg(9'd3, 8'd7, 5'd0);
        send_req(REQ_RD_OFF, 49'd1000, 32'd2000, WH_START);
        settle();

        // widest layout: physical offsets reach the top of the space
        apply_cfg(9'd256, 8'd255, 5'd31);
        send_req(REQ_WR_OFF, 49'h0_FFFF_0000_0000, 32'hFFFF_FFFF, WH_START);
        send_req(REQ_SEEK, '0, 32'd0, WH_END);
        send_req(REQ_WR_POS, '0, 32'd0, WH_START);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_on  = (ph != 2 && ph != 5);
            stall_on = (ph != 4 && ph != 5);
            case (ph)
                0: apply_cfg(9'd2, 8'd1, 5'd9);
                1: apply_cfg(9'd256, 8'd255, 5'd30);
                2: apply_cfg(9'd1, 8'd0, 5'd9);
                5: apply_cfg(9'd7, 8'd3, 5'd12);
                default:
                begin
                    ch_pick = $urandom_range(2, 256);
                    apply_cfg(CH_W'(ch_pick), IDX_W'($urandom_range(0, ch_pick - 1)),
                              BS_W'($urandom_range(BS_MIN, BS_MAX)));
                end
            endcase
            useful = 0;
            while (useful < PHASE_ITEMS)
            begin
                random_request(counted);
                if (counted)
                    useful++;
            end
            settle();
        end

        $display("covered %0d requests and %0d result transfers in %0d cycles",
                 requests_seen, results_seen, cycles);
        $display("directed corner cases, then six register settings with and without gaps");
        if (mismatches == 0 && due_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
